// ===== hdl/huffman_code_bit_packer_defines.svh =====
// Assertion macros shared by the Huffman code bit packer RTL.
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCBP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HCBP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hcbp_pkg.sv =====
// Package with constants and function codes of the Huffman code bit packer.
`timescale 1ns / 1ps

package hcbp_pkg;

    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int MAX_CODE_LEN_DEF = 32;

    localparam int BYTE_BITS  = 8;
    localparam int BYTE_SHIFT = 3;

    localparam int FUNC_W        = 2;
    localparam int SYMBOL_W      = 8;
    localparam int CODE_BITS_W   = 32;
    localparam int CODE_LENGTH_W = 6;
    localparam int PAD_W         = 3;
    localparam int PEND_W        = 7;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

endpackage

// ===== hdl/huffman_code_bit_packer.sv =====
// Huffman code bit packer: code table lookup, bit accumulator and byte emitter.
// The first result of an item passes the table read register, the emitter registers and
// the output register. Throughput: one result per cycle while the output is not stalled;
// an item gives up to (MAX_CODE_LEN + 7) / 8 results through the single byte lane of the
// emitter. Loads give no result. Reset (aresetn low, synchronous) clears the pending bits
// and the table valid bits; no clearing pass is needed.
`timescale 1ns / 1ps

module huffman_code_bit_packer #(
    parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: symbol [7:0], code_bits [39:8], code_length [45:40], zero [47:46]
    input  logic [hcbp_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: func [1:0]
    input  logic [hcbp_pkg::FUNC_W-1:0]      s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // m_tdata: data_byte [7:0], pad_bits [10:8], zero [15:11]
    output logic [hcbp_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: byte_valid [0], unknown_symbol [1]
    output logic [hcbp_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                             m_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready
);

    localparam int ADDR_W   = $clog2(SYMBOL_COUNT);
    localparam int LEN_W    = $clog2(MAX_CODE_LEN + 1);
    localparam int ENTRY_W  = LEN_W + MAX_CODE_LEN;
    localparam int ACC_W    = hcbp_pkg::PEND_W + MAX_CODE_LEN;
    localparam int N_W      = $clog2(ACC_W + 1);
    localparam int LEFT_MAX = ACC_W / hcbp_pkg::BYTE_BITS;
    localparam int LEFT_W   = $clog2(LEFT_MAX + 1);

    // ---------------------------------------------------------------- input decode
    logic                                in_accept;
    logic [hcbp_pkg::FUNC_W-1:0]         in_func;
    logic [hcbp_pkg::SYMBOL_W-1:0]       in_symbol;
    logic [hcbp_pkg::CODE_BITS_W-1:0]    in_code;
    logic [hcbp_pkg::CODE_LENGTH_W-1:0]  in_len;
    logic [hcbp_pkg::CODE_LENGTH_W-1:0]  in_len_sat;
    logic                                in_range;
    logic [MAX_CODE_LEN-1:0]             in_code_masked;

    logic                                wr_en;
    logic                                rd_en;
    logic [ENTRY_W-1:0]                  wr_data;
    logic [ENTRY_W-1:0]                  rd_data;

    assign in_accept = s_tvalid && s_tready;
    assign in_func   = s_tuser;
    assign in_symbol = s_tdata[7:0];
    assign in_code   = s_tdata[39:8];
    assign in_len    = s_tdata[45:40];
    assign in_range  = {1'b0, in_symbol} < 9'(SYMBOL_COUNT);

    assign in_len_sat = (in_len > hcbp_pkg::CODE_LENGTH_W'(MAX_CODE_LEN))
                      ? hcbp_pkg::CODE_LENGTH_W'(MAX_CODE_LEN) : in_len;
    // Shifting the all-ones word by the full length leaves a mask of all ones.
    assign in_code_masked = in_code[MAX_CODE_LEN-1:0]
                          & ~({MAX_CODE_LEN{1'b1}} << in_len_sat);

    assign wr_en   = in_accept && (in_func == hcbp_pkg::FUNC_LOAD) && in_range;
    assign wr_data = {in_len_sat[LEN_W-1:0], in_code_masked};
    assign rd_en   = in_accept && (in_func == hcbp_pkg::FUNC_ENCODE);

    hcbp_code_table #(
        .DEPTH   (SYMBOL_COUNT),
        .ADDR_W  (ADDR_W),
        .ENTRY_W (ENTRY_W)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (in_symbol[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (in_symbol[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // ---------------------------------------------------------------- lookup stage
    logic                        b_valid_reg, b_valid_next;
    logic                        b_flush_reg, b_flush_next;
    logic                        b_range_reg, b_range_next;
    logic [hcbp_pkg::PEND_W-1:0] pend_reg, pend_next;
    logic [2:0]                  pend_cnt_reg, pend_cnt_next;

    logic [LEN_W-1:0]            b_len;
    logic [MAX_CODE_LEN-1:0]     b_code;
    logic                        b_unknown;
    logic [ACC_W-1:0]            b_acc;
    logic [N_W-1:0]              b_n;
    logic [LEFT_W-1:0]           b_bytes;
    logic [2:0]                  b_new_cnt;
    logic [hcbp_pkg::PEND_W-1:0] b_new_pend;
    logic [hcbp_pkg::PAD_W-1:0]  b_pad;
    logic [7:0]                  b_flush_byte;
    logic                        b_flush_bv;
    logic                        b_needs_emit;
    logic                        b_go;

    // ---------------------------------------------------------------- emitter
    logic [ACC_W-1:0]            e_acc_reg, e_acc_next;
    logic [N_W-1:0]              e_n_reg, e_n_next;
    logic [LEFT_W-1:0]           e_left_reg, e_left_next;
    logic                        e_bv_reg, e_bv_next;
    logic                        e_unk_reg, e_unk_next;
    logic [hcbp_pkg::PAD_W-1:0]  e_pad_reg, e_pad_next;
    logic                        e_fire;
    logic                        e_free;
    logic [7:0]                  e_byte;

    logic                        out_load;
    logic                        m_valid_reg, m_valid_next;
    logic [7:0]                  m_byte_reg, m_byte_next;
    logic [hcbp_pkg::PAD_W-1:0]  m_pad_reg, m_pad_next;
    logic                        m_bv_reg, m_bv_next;
    logic                        m_unk_reg, m_unk_next;
    logic                        m_last_reg, m_last_next;

    assign b_len     = rd_data[ENTRY_W-1:MAX_CODE_LEN];
    assign b_code    = rd_data[MAX_CODE_LEN-1:0];
    assign b_unknown = !b_flush_reg && (!b_range_reg || (b_len == '0));

    assign b_acc      = (ACC_W'(pend_reg) << b_len) | ACC_W'(b_code);
    assign b_n        = N_W'(pend_cnt_reg) + N_W'(b_len);
    assign b_bytes    = LEFT_W'(b_n >> hcbp_pkg::BYTE_SHIFT);
    assign b_new_cnt  = b_n[2:0];
    assign b_new_pend = b_acc[hcbp_pkg::PEND_W-1:0]
                      & ~({hcbp_pkg::PEND_W{1'b1}} << b_new_cnt);

    // The pad count is the distance to the next byte boundary, zero when empty.
    assign b_pad        = hcbp_pkg::PAD_W'(hcbp_pkg::BYTE_BITS - int'(pend_cnt_reg));
    assign b_flush_byte = 8'({1'b0, pend_reg} << b_pad);
    assign b_flush_bv   = (pend_cnt_reg != 3'd0);

    assign b_needs_emit = b_flush_reg || b_unknown || (b_bytes != '0);
    assign out_load     = !m_valid_reg || m_tready;
    assign e_fire       = (e_left_reg != '0) && out_load;
    assign e_free       = (e_left_reg == '0) || ((e_left_reg == LEFT_W'(1)) && out_load);
    assign b_go         = b_valid_reg && (!b_needs_emit || e_free);
    assign s_tready     = !b_valid_reg || b_go;

    always_comb begin
        b_valid_next = b_valid_reg;
        b_flush_next = b_flush_reg;
        b_range_next = b_range_reg;
        if (in_accept) begin
            b_valid_next = (in_func == hcbp_pkg::FUNC_ENCODE)
                        || (in_func == hcbp_pkg::FUNC_FLUSH);
            b_flush_next = (in_func == hcbp_pkg::FUNC_FLUSH);
            b_range_next = in_range;
        end else if (b_go) begin
            b_valid_next = 1'b0;
        end
    end

    always_comb begin
        pend_next     = pend_reg;
        pend_cnt_next = pend_cnt_reg;
        if (b_go) begin
            if (b_flush_reg) begin
                pend_next     = '0;
                pend_cnt_next = 3'd0;
            end else if (!b_unknown) begin
                pend_next     = b_new_pend;
                pend_cnt_next = b_new_cnt;
            end
        end
    end

    always_comb begin
        e_acc_next  = e_acc_reg;
        e_n_next    = e_n_reg;
        e_left_next = e_left_reg;
        e_bv_next   = e_bv_reg;
        e_unk_next  = e_unk_reg;
        e_pad_next  = e_pad_reg;
        if (e_fire) begin
            e_n_next    = e_n_reg - N_W'(hcbp_pkg::BYTE_BITS);
            e_left_next = e_left_reg - LEFT_W'(1);
        end
        if (b_go && b_needs_emit) begin
            if (b_flush_reg) begin
                e_acc_next  = ACC_W'(b_flush_byte);
                e_n_next    = N_W'(hcbp_pkg::BYTE_BITS);
                e_left_next = LEFT_W'(1);
                e_bv_next   = b_flush_bv;
                e_unk_next  = 1'b0;
                e_pad_next  = b_pad;
            end else if (b_unknown) begin
                e_acc_next  = '0;
                e_n_next    = N_W'(hcbp_pkg::BYTE_BITS);
                e_left_next = LEFT_W'(1);
                e_bv_next   = 1'b0;
                e_unk_next  = 1'b1;
                e_pad_next  = '0;
            end else begin
                e_acc_next  = b_acc;
                e_n_next    = b_n;
                e_left_next = b_bytes;
                e_bv_next   = 1'b1;
                e_unk_next  = 1'b0;
                e_pad_next  = '0;
            end
        end
    end

    // The next byte is the oldest eight of the remaining bits.
    assign e_byte = 8'(e_acc_reg >> (e_n_reg - N_W'(hcbp_pkg::BYTE_BITS)));

    always_comb begin
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_pad_next   = m_pad_reg;
        m_bv_next    = m_bv_reg;
        m_unk_next   = m_unk_reg;
        m_last_next  = m_last_reg;
        if (e_fire) begin
            m_valid_next = 1'b1;
            m_byte_next  = e_byte;
            m_pad_next   = e_pad_reg;
            m_bv_next    = e_bv_reg;
            m_unk_next   = e_unk_reg;
            m_last_next  = (e_left_reg == LEFT_W'(1));
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg  <= 1'b0;
            pend_reg     <= '0;
            pend_cnt_reg <= 3'd0;
            e_left_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            b_valid_reg  <= b_valid_next;
            pend_reg     <= pend_next;
            pend_cnt_reg <= pend_cnt_next;
            e_left_reg   <= e_left_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_flush_reg <= b_flush_next;
        b_range_reg <= b_range_next;
        e_acc_reg   <= e_acc_next;
        e_n_reg     <= e_n_next;
        e_bv_reg    <= e_bv_next;
        e_unk_reg   <= e_unk_next;
        e_pad_reg   <= e_pad_next;
        m_byte_reg  <= m_byte_next;
        m_pad_reg   <= m_pad_next;
        m_bv_reg    <= m_bv_next;
        m_unk_reg   <= m_unk_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_pad_reg, m_byte_reg};
    assign m_tuser  = {m_unk_reg, m_bv_reg};
    assign m_tlast  = m_last_reg;

    // ---------------------------------------------------------------- assertions
`include "huffman_code_bit_packer_defines.svh"

    `HCBP_ASSERT_IMP(a_fire_has_byte, aclk, aresetn, e_fire, e_n_reg >= N_W'(hcbp_pkg::BYTE_BITS), "emitter fired without a full byte")
    `HCBP_ASSERT_IMP(a_pend_clean, aclk, aresetn, 1'b1, (pend_reg & ({hcbp_pkg::PEND_W{1'b1}} << pend_cnt_reg)) == '0, "stale bits above pending count")
    `HCBP_ASSERT_NXT(a_unknown_keeps, aclk, aresetn, b_go && b_unknown, $stable(pend_cnt_reg) && $stable(pend_reg), "unknown symbol changed accumulator")
    `HCBP_ASSERT_IMP(a_unknown_alone, aclk, aresetn, m_valid_reg && m_unk_reg, !m_bv_reg && m_last_reg, "unknown result carries a byte")

endmodule

// ===== hdl/hcbp_code_table.sv =====
// Code table memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps

module hcbp_code_table #(
    parameter int DEPTH   = hcbp_pkg::SYMBOL_COUNT_DEF,
    parameter int ADDR_W  = $clog2(hcbp_pkg::SYMBOL_COUNT_DEF),
    parameter int ENTRY_W = 38
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0]   vld_reg;
    logic [ENTRY_W-1:0] rd_raw_reg;
    logic               rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_raw_reg <= mem_reg[rd_addr];
        end
    end

    // Valid bits stand in for clearing the whole array at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_raw_reg : '0;

endmodule
